// ===== rtl/core/stmt_pkg.sv =====
// Shared types and constants for the sequence tag match table.
// Used by stmt_ctrl, stmt_dp and sequence_tag_match_table; no dependencies.
`default_nettype none

package stmt_pkg;

    localparam int unsigned KEY_W    = 16;
    localparam int unsigned VAL_W    = 63;
    localparam int unsigned STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_MISSING = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic    load_req;   // capture request fields
        logic    ram_rd;     // issue table read
        logic    rd_next;    // read slot idx+1 instead of idx
        logic    ram_wr;     // write table slot
        logic    wr_shift;   // write read data to slot idx (compaction)
        logic    clr_idx;
        logic    inc_idx;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    hit_cap;    // keep value of matching entry
        logic    out_load;   // load result register
        logic    out_hit;    // result carries the captured value
        status_t out_status;
    } stmt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op;
        logic full;
        logic empty;
        logic key_match;
        logic idx_last;      // idx is the youngest valid slot
    } stmt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/stmt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module stmt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stmt_dp.sv =====
// Datapath: request capture, entry table (stmt_ram), fill count, scan index
// and result register. Depends on stmt_pkg and stmt_ram.
`default_nettype none

module stmt_dp
    import stmt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire stmt_cmd_t        cmd,
    output stmt_sts_t             sts,
    input  wire logic             s_opcode,
    input  wire logic [KEY_W-1:0] s_seq_number,
    input  wire logic [VAL_W-1:0] s_value_in,
    output status_t               m_status,
    output logic      [VAL_W-1:0] m_value_out
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned ENT_W = KEY_W + VAL_W;

    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [VAL_W-1:0] hit_val_reg;
    status_t          status_reg;
    logic [VAL_W-1:0] value_out_reg;

    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;

    assign wr_addr = cmd.wr_shift ? idx_reg : cnt_reg[IDX_W-1:0];
    assign wr_data = cmd.wr_shift ? rd_data : {key_reg, val_reg};
    assign rd_addr = cmd.rd_next ? (idx_reg + IDX_W'(1)) : idx_reg;

    stmt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.ram_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        sts.op        = op_reg;
        sts.full      = (cnt_reg == CNT_W'(TABLE_DEPTH));
        sts.empty     = (cnt_reg == '0);
        sts.key_match = (rd_data[VAL_W +: KEY_W] == key_reg);
        sts.idx_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg  <= s_opcode;
            key_reg <= s_seq_number;
            val_reg <= s_value_in;
        end
        if (cmd.clr_idx) begin
            idx_reg <= '0;
        end else if (cmd.inc_idx) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.hit_cap) begin
            hit_val_reg <= rd_data[VAL_W-1:0];
        end
        if (cmd.out_load) begin
            status_reg    <= cmd.out_status;
            value_out_reg <= cmd.out_hit ? hit_val_reg : '0;
        end
    end

    assign m_status    = status_reg;
    assign m_value_out = value_out_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_no_insert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> !sts.full && cmd.ram_wr && !cmd.wr_shift)
        else $error("append without a free slot");

    a_no_remove_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> !sts.empty && sts.idx_last)
        else $error("removal from empty table or before compaction ends");

endmodule

`default_nettype wire

// ===== rtl/core/stmt_ctrl.sv =====
// Controller: sequences insert, oldest-first search and compaction,
// and owns the request/result handshakes. Depends on stmt_pkg.
`default_nettype none

module stmt_ctrl
    import stmt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire stmt_sts_t sts,
    output stmt_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    logic    m_valid_reg, m_valid_next;
    status_t res_status_reg, res_status_next;
    logic    res_hit_reg, res_hit_next;
    logic    out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd             = '0;
        cmd.out_status  = res_status_reg;
        cmd.out_hit     = res_hit_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                res_hit_next = 1'b0;
                if (sts.op == OP_INSERT) begin
                    if (sts.full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        cmd.ram_wr      = 1'b1;
                        cmd.cnt_inc     = 1'b1;
                        res_status_next = ST_OK;
                    end
                    state_next = S_RESULT;
                end else if (sts.empty) begin
                    res_status_next = ST_MISSING;
                    state_next      = S_RESULT;
                end else begin
                    cmd.clr_idx = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                cmd.ram_rd = 1'b1;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (sts.key_match) begin
                    cmd.hit_cap = 1'b1;
                    state_next  = S_SHIFT_CHK;
                end else if (sts.idx_last) begin
                    res_status_next = ST_MISSING;
                    state_next      = S_RESULT;
                end else begin
                    cmd.inc_idx = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SHIFT_CHK: begin
                // idx holds the slot being filled from its younger neighbor
                if (sts.idx_last) begin
                    cmd.cnt_dec     = 1'b1;
                    res_status_next = ST_OK;
                    res_hit_next    = 1'b1;
                    state_next      = S_RESULT;
                end else begin
                    cmd.ram_rd  = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.ram_wr   = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.inc_idx  = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            res_status_reg <= ST_OK;
            res_hit_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            res_status_reg <= res_status_next;
            res_hit_reg    <= res_hit_next;
        end
    end

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register overwritten before it was taken");

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");

    a_hit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && cmd.out_hit |-> cmd.out_status == ST_OK)
        else $error("returned value with error status");

endmodule

`default_nettype wire

// ===== rtl/core/sequence_tag_match_table.sv =====
// Top level of the sequence tag match table: controller plus datapath.
// Depends on stmt_pkg, stmt_ctrl, stmt_dp (and stmt_ram through stmt_dp).
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   request  | s_valid / s_ready   | s_opcode, s_seq_number, s_value_in
//   result   | m_valid / m_ready   | m_status, m_value_out
//
// Insert, full-table insert or take on an empty table: the request is decoded,
// then the result loads. Take: each slot scanned (every valid slot on a miss)
// is read, then compared; on a hit, each younger entry is shifted down by a
// read and a write. The next request is taken the cycle after the result loads.
// aresetn (synchronous) clears the fill count and control; no clearing pass.
// A finished result waits in its register while the next request is taken;
// a new result stalls only if the previous one is still held.
`default_nettype none

module sequence_tag_match_table
    import stmt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_opcode,
    input  wire logic [KEY_W-1:0] s_seq_number,
    input  wire logic [VAL_W-1:0] s_value_in,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic      [VAL_W-1:0] m_value_out
);

    stmt_cmd_t cmd;
    stmt_sts_t sts;

    stmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    stmt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_opcode     (s_opcode),
        .s_seq_number (s_seq_number),
        .s_value_in   (s_value_in),
        .m_status     (m_status),
        .m_value_out  (m_value_out)
    );

endmodule

`default_nettype wire
